// ===== rtl/spct_pkg.sv =====
// spct_pkg: shared constants, types and status codes of the symmetric pair count table
// used by spct_hash, spct_heads, spct_pool and symmetric_pair_count_table
// no dependencies
package spct_pkg;

	// table geometry, BUCKETS is a power of two so the bucket is the low hash bits
	localparam int unsigned BUCKETS      = 1024;
	localparam int unsigned POOL_ENTRIES = 4096;
	localparam int unsigned WORD_ID_BITS = 20;

	localparam int unsigned BUCKET_BITS   = $clog2(BUCKETS);
	localparam int unsigned POOL_IDX_BITS = $clog2(POOL_ENTRIES);
	// link coding: zero is null, otherwise pool index plus one
	localparam int unsigned LINK_BITS     = $clog2(POOL_ENTRIES + 1);
	localparam int unsigned COUNT_BITS    = 32;

	localparam logic [31:0] HASH_MULT = 32'd31337;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		ST_INCREMENTED = 3'd0,
		ST_INSERTED    = 3'd1,
		ST_DROPPED     = 3'd2,
		ST_SELF        = 3'd3,
		ST_HIT         = 3'd4,
		ST_MISS        = 3'd5
	} status_t;

	typedef struct packed {
		logic [WORD_ID_BITS-1:0] word_one;
		logic [WORD_ID_BITS-1:0] word_two;
		logic [COUNT_BITS-1:0]   count;
		logic [LINK_BITS-1:0]    link;
	} entry_t;

	typedef struct packed {
		logic                     en;
		logic [BUCKET_BITS-1:0]   addr;
		logic [LINK_BITS-1:0]     data;
	} heads_wr_t;

	typedef struct packed {
		logic                     en;
		logic [POOL_IDX_BITS-1:0] addr;
		entry_t                   data;
	} pool_wr_t;

endpackage

// ===== rtl/symmetric_pair_count_table.sv =====
// symmetric_pair_count_table: top level, request sequencer over the head and pool memories
// depends on spct_pkg, spct_hash, spct_heads, spct_pool
//
// Counts unordered word pairs in a chained hash table. After reset the bucket heads are
// swept clear, one bucket a cycle, and req_stall stays high until the sweep is done. One
// request is worked at a time. A self pair goes straight to the result state. Otherwise the
// registered hash is followed by the head read and the walk down the chain, where every
// chain step is one registered read of the pool memory. A result waits in the output
// register while the next request is taken.
module symmetric_pair_count_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                req_type,
	input  logic [spct_pkg::WORD_ID_BITS-1:0]   first_word,
	input  logic [spct_pkg::WORD_ID_BITS-1:0]   second_word,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic [2:0]                          status,
	output logic [spct_pkg::COUNT_BITS-1:0]     pair_count
);

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_HEAD   = 6'b000100,
		S_WALK   = 6'b001000,
		S_CHECK  = 6'b010000,
		S_RESULT = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic                                 lookup_q;
	logic [spct_pkg::WORD_ID_BITS-1:0]    x_q;
	logic [spct_pkg::WORD_ID_BITS-1:0]    y_q;
	logic [spct_pkg::POOL_IDX_BITS-1:0]   rd_idx_q;
	logic [spct_pkg::LINK_BITS-1:0]       pool_used_q;
	spct_pkg::status_t                    fin_status_q;
	logic [spct_pkg::COUNT_BITS-1:0]      fin_count_q;
	logic                                 res_valid_q;
	spct_pkg::status_t                    status_q;
	logic [spct_pkg::COUNT_BITS-1:0]      pair_count_q;

	logic [spct_pkg::BUCKET_BITS-1:0]     bucket;
	logic                                 heads_rd_en;
	logic [spct_pkg::LINK_BITS-1:0]       head_link;
	logic                                 heads_busy;
	spct_pkg::heads_wr_t                  heads_wr;
	logic                                 pool_rd_en;
	logic [spct_pkg::POOL_IDX_BITS-1:0]   pool_rd_addr;
	spct_pkg::entry_t                     entry;
	spct_pkg::pool_wr_t                   pool_wr;

	logic                                 out_free;
	logic                                 req_accept;
	logic                                 self_pair;
	logic                                 pool_full;
	logic                                 match;
	logic [spct_pkg::LINK_BITS-1:0]       chain_link;
	logic                                 insert;
	logic                                 fin;
	spct_pkg::status_t                    fin_status;
	logic [spct_pkg::COUNT_BITS-1:0]      fin_count;
	logic [spct_pkg::COUNT_BITS-1:0]      bumped;

	spct_hash u_hash (
		.clk         (clk),
		.en          (req_accept),
		.first_word  (first_word),
		.second_word (second_word),
		.bucket      (bucket)
	);

	spct_heads u_heads (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (heads_rd_en),
		.rd_addr (bucket),
		.rd_data (head_link),
		.wr      (heads_wr),
		.busy    (heads_busy)
	);

	spct_pool u_pool (
		.clk     (clk),
		.rd_en   (pool_rd_en),
		.rd_addr (pool_rd_addr),
		.rd_data (entry),
		.wr      (pool_wr)
	);

	assign out_free   = !res_valid_q || !res_stall;
	assign req_stall  = !((state_q == S_IDLE) || (state_q == S_RESULT && out_free));
	assign req_accept = req_valid && !req_stall;
	assign self_pair  = (first_word == second_word);
	assign pool_full  = (pool_used_q == spct_pkg::LINK_BITS'(spct_pkg::POOL_ENTRIES));
	assign match      = (entry.word_one == x_q && entry.word_two == y_q)
	                 || (entry.word_one == y_q && entry.word_two == x_q);
	// the walk starts at the head word and then follows each entry's link
	assign chain_link = (state_q == S_WALK) ? head_link : entry.link;
	assign bumped     = (entry.count == spct_pkg::COUNT_MAX) ? entry.count
	                  : entry.count + spct_pkg::COUNT_BITS'(1);

	always_comb begin
		state_d      = state_q;
		heads_rd_en  = 1'b0;
		pool_rd_en   = 1'b0;
		pool_rd_addr = rd_idx_q;
		heads_wr     = '0;
		pool_wr      = '0;
		insert       = 1'b0;
		fin          = 1'b0;
		fin_status   = spct_pkg::ST_MISS;
		fin_count    = '0;
		unique case (state_q)
			S_CLEAR: begin
				if (!heads_busy) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE, S_RESULT: begin
				if (req_accept) begin
					if (self_pair) begin
						fin        = 1'b1;
						fin_status = spct_pkg::ST_SELF;
						state_d    = S_RESULT;
					end else begin
						state_d = S_HEAD;
					end
				end else if (state_q == S_RESULT && out_free) begin
					state_d = S_IDLE;
				end
			end
			S_HEAD: begin
				heads_rd_en = 1'b1;
				state_d     = S_WALK;
			end
			S_WALK, S_CHECK: begin
				if (state_q == S_CHECK && match) begin
					fin     = 1'b1;
					state_d = S_RESULT;
					if (lookup_q) begin
						fin_status = spct_pkg::ST_HIT;
						fin_count  = entry.count;
					end else begin
						fin_status         = spct_pkg::ST_INCREMENTED;
						fin_count          = bumped;
						pool_wr.en         = 1'b1;
						pool_wr.addr       = rd_idx_q;
						pool_wr.data       = entry;
						pool_wr.data.count = bumped;
					end
				end else if (chain_link == '0) begin
					fin     = 1'b1;
					state_d = S_RESULT;
					if (lookup_q) begin
						fin_status = spct_pkg::ST_MISS;
					end else if (pool_full) begin
						fin_status = spct_pkg::ST_DROPPED;
					end else begin
						// push a new entry at the bucket head
						insert                = 1'b1;
						fin_status            = spct_pkg::ST_INSERTED;
						fin_count             = spct_pkg::COUNT_BITS'(1);
						pool_wr.en            = 1'b1;
						pool_wr.addr          = pool_used_q[spct_pkg::POOL_IDX_BITS-1:0];
						pool_wr.data.word_one = x_q;
						pool_wr.data.word_two = y_q;
						pool_wr.data.count    = spct_pkg::COUNT_BITS'(1);
						pool_wr.data.link     = head_link;
						heads_wr.en           = 1'b1;
						heads_wr.addr         = bucket;
						heads_wr.data         = pool_used_q + spct_pkg::LINK_BITS'(1);
					end
				end else begin
					pool_rd_en   = 1'b1;
					pool_rd_addr = spct_pkg::POOL_IDX_BITS'(chain_link - spct_pkg::LINK_BITS'(1));
					state_d      = S_CHECK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			pool_used_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (insert) begin
				pool_used_q <= pool_used_q + spct_pkg::LINK_BITS'(1);
			end
			if (state_q == S_RESULT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			lookup_q <= req_type;
			x_q      <= first_word;
			y_q      <= second_word;
		end
		if (pool_rd_en) begin
			rd_idx_q <= pool_rd_addr;
		end
		if (fin) begin
			fin_status_q <= fin_status;
			fin_count_q  <= fin_count;
		end
		if (state_q == S_RESULT && out_free) begin
			status_q     <= fin_status_q;
			pair_count_q <= fin_count_q;
		end
	end

	assign res_valid  = res_valid_q;
	assign status     = status_q;
	assign pair_count = pair_count_q;

	a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		heads_busy |-> req_stall)
		else $error("request taken during head clearing sweep");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pool_used_q <= spct_pkg::LINK_BITS'(spct_pkg::POOL_ENTRIES))
		else $error("pool fill count beyond pool size");

	a_insert_takes_one: assert property (@(posedge clk) disable iff (!arst_n)
		insert |=> pool_used_q == $past(pool_used_q) + spct_pkg::LINK_BITS'(1))
		else $error("insert did not take exactly one pool entry");

	a_result_from_sequencer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == S_RESULT))
		else $error("result word loaded outside the result state");

endmodule

// ===== rtl/spct_hash.sv =====
// spct_hash: symmetric pair hash, one multiply registered, bucket taken after the register
// depends on spct_pkg
module spct_hash (
	input  logic                                clk,
	input  logic                                en,
	input  logic [spct_pkg::WORD_ID_BITS-1:0]   first_word,
	input  logic [spct_pkg::WORD_ID_BITS-1:0]   second_word,
	output logic [spct_pkg::BUCKET_BITS-1:0]    bucket
);

	logic [spct_pkg::WORD_ID_BITS-1:0] lo;
	logic [spct_pkg::WORD_ID_BITS-1:0] hi;
	logic [31:0]                       prod;
	logic [31:0]                       prod_q;
	logic [spct_pkg::WORD_ID_BITS-1:0] hi_q;

	always_comb begin
		if (first_word < second_word) begin
			lo = first_word;
			hi = second_word;
		end else begin
			lo = second_word;
			hi = first_word;
		end
		prod = 32'(lo) * spct_pkg::HASH_MULT;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= prod;
			hi_q   <= hi;
		end
	end

	// modulo a power of two keeps the low bits
	assign bucket = spct_pkg::BUCKET_BITS'(prod_q ^ 32'(hi_q));

endmodule

// ===== rtl/spct_heads.sv =====
// spct_heads: bucket head memory with a clearing sweep after reset
// depends on spct_pkg
module spct_heads (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rd_en,
	input  logic [spct_pkg::BUCKET_BITS-1:0]  rd_addr,
	output logic [spct_pkg::LINK_BITS-1:0]    rd_data,
	input  spct_pkg::heads_wr_t               wr,
	output logic                              busy
);

	logic [spct_pkg::LINK_BITS-1:0]   mem [spct_pkg::BUCKETS];
	logic [spct_pkg::LINK_BITS-1:0]   rd_data_q;
	logic [spct_pkg::BUCKET_BITS-1:0] clr_idx_q;
	logic                             busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			clr_idx_q <= clr_idx_q + spct_pkg::BUCKET_BITS'(1);
			if (clr_idx_q == spct_pkg::BUCKET_BITS'(spct_pkg::BUCKETS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

// ===== rtl/spct_pool.sv =====
// spct_pool: entry pool memory, words, count and chain link in one row
// depends on spct_pkg
module spct_pool (
	input  logic                                clk,
	input  logic                                rd_en,
	input  logic [spct_pkg::POOL_IDX_BITS-1:0]  rd_addr,
	output spct_pkg::entry_t                    rd_data,
	input  spct_pkg::pool_wr_t                  wr
);

	spct_pkg::entry_t mem [spct_pkg::POOL_ENTRIES];
	spct_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== dv/tb.sv =====
// tb: self-checking bench for symmetric_pair_count_table, tallying every pair it sends
// and comparing each status word against its own copy of the chained table
// depends on spct_pkg and the symmetric_pair_count_table rtl
module tb;
	import spct_pkg::*;

	localparam logic REQ_INCR   = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;
	localparam int unsigned UP_BITS = WORD_ID_BITS - BUCKET_BITS;

	typedef struct packed {
		logic                    kind;
		logic [WORD_ID_BITS-1:0] one;
		logic [WORD_ID_BITS-1:0] two;
	} pair_req_t;

	typedef struct packed {
		status_t               status;
		logic [COUNT_BITS-1:0] count;
	} tally_t;

	logic                    clk;
	logic                    arst_n;
	logic                    req_valid;
	logic                    req_stall;
	logic                    req_type;
	logic [WORD_ID_BITS-1:0] first_word;
	logic [WORD_ID_BITS-1:0] second_word;
	logic                    res_valid;
	logic                    res_stall;
	logic [2:0]              status;
	logic [COUNT_BITS-1:0]   pair_count;

	symmetric_pair_count_table dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.first_word  (first_word),
		.second_word (second_word),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.status      (status),
		.pair_count  (pair_count)
	);

	// own copy of the table, links coded as pool index plus one
	int unsigned           chain_head [BUCKETS];
	logic [WORD_ID_BITS-1:0] slot_one [POOL_ENTRIES];
	logic [WORD_ID_BITS-1:0] slot_two [POOL_ENTRIES];
	logic [COUNT_BITS-1:0] slot_count [POOL_ENTRIES];
	int unsigned           slot_next [POOL_ENTRIES];
	int unsigned           slots_taken;

	pair_req_t   pair_reqs[$];
	tally_t      due_tallies[$];
	int unsigned mismatches;
	int unsigned accepted_n;
	bit          req_taken;
	bit          calm;
	int unsigned gap_left;
	int unsigned stall_left;
	int unsigned hold_left;
	bit          held_once;

	logic [WORD_ID_BITS-1:0] vocab [16];
	logic [WORD_ID_BITS-1:0] mate_lo [4];
	logic [BUCKET_BITS-1:0]  mate_bkt [2];

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic tally_t tally_pair(pair_req_t r);
		logic [WORD_ID_BITS-1:0] lo;
		logic [WORD_ID_BITS-1:0] hi;
		logic [31:0] h;
		int unsigned bkt;
		int unsigned link;
		int unsigned idx;
		tally_t t;
		t.status = ST_SELF;
		t.count  = '0;
		if (r.one == r.two)
			return t;
		lo = (r.one < r.two) ? r.one : r.two;
		hi = (r.one < r.two) ? r.two : r.one;
		h = (32'(lo) * HASH_MULT) ^ 32'(hi);
		bkt = h % BUCKETS;
		link = chain_head[bkt];
		while (link != 0 && !((slot_one[link-1] == r.one && slot_two[link-1] == r.two) ||
				(slot_one[link-1] == r.two && slot_two[link-1] == r.one)))
			link = slot_next[link-1];
		if (r.kind == REQ_LOOKUP) begin
			if (link != 0) begin
				t.status = ST_HIT;
				t.count  = slot_count[link-1];
			end else begin
				t.status = ST_MISS;
			end
		end else if (link != 0) begin
			idx = link - 1;
			if (slot_count[idx] != COUNT_MAX)
				slot_count[idx] = slot_count[idx] + 1;
			t.status = ST_INCREMENTED;
			t.count  = slot_count[idx];
		end else if (slots_taken < POOL_ENTRIES) begin
			idx = slots_taken;
			slot_one[idx]   = r.one;
			slot_two[idx]   = r.two;
			slot_count[idx] = 1;
			slot_next[idx]  = chain_head[bkt];
			chain_head[bkt] = idx + 1;
			slots_taken     = idx + 1;
			t.status = ST_INSERTED;
			t.count  = 1;
		end else begin
			t.status = ST_DROPPED;
		end
		return t;
	endfunction

	// word that lands in bucket bkt when paired with lo (lo below 2**BUCKET_BITS, up nonzero)
	function automatic logic [WORD_ID_BITS-1:0] bucket_mate(logic [WORD_ID_BITS-1:0] lo,
			logic [BUCKET_BITS-1:0] bkt, logic [UP_BITS-1:0] up);
		logic [31:0] prod;
		prod = 32'(lo) * HASH_MULT;
		return {up, bkt ^ prod[BUCKET_BITS-1:0]};
	endfunction

	task automatic queue_req(logic kind, logic [WORD_ID_BITS-1:0] a, logic [WORD_ID_BITS-1:0] b);
		pair_req_t r;
		r.kind = kind;
		r.one  = a;
		r.two  = b;
		pair_reqs.push_back(r);
	endtask

	function automatic pair_req_t rand_pair();
		pair_req_t r;
		logic [WORD_ID_BITS-1:0] w;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		r.kind = ($urandom_range(0, 3) == 0) ? REQ_LOOKUP : REQ_INCR;
		if (pick < 50) begin
			r.one = vocab[$urandom_range(0, 15)];
			r.two = vocab[$urandom_range(0, 15)];
		end else if (pick < 80) begin
			// crowd two buckets to get long chains
			r.one = mate_lo[$urandom_range(0, 3)];
			r.two = bucket_mate(r.one, mate_bkt[$urandom_range(0, 1)],
				UP_BITS'($urandom_range(1, 12)));
		end else if (pick < 94) begin
			r.kind = 1'($urandom_range(0, 1));
			r.one  = WORD_ID_BITS'($urandom);
			r.two  = WORD_ID_BITS'($urandom);
		end else begin
			r.kind = 1'($urandom_range(0, 1));
			r.one  = WORD_ID_BITS'($urandom);
			r.two  = r.one;
		end
		if ($urandom_range(0, 1) == 1) begin
			w     = r.one;
			r.one = r.two;
			r.two = w;
		end
		return r;
	endfunction

	// sender, changes only at the falling edge
	always @(negedge clk) begin
		pair_req_t r;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (req_valid && !req_taken) begin
			// word stalled, hold it
		end else if (gap_left > 0) begin
			gap_left  <= gap_left - 1;
			req_valid <= 1'b0;
		end else if (pair_reqs.size() > 0) begin
			if (!calm && $urandom_range(0, 7) == 0) begin
				gap_left  <= $urandom_range(0, 6);
				req_valid <= 1'b0;
			end else begin
				r = pair_reqs.pop_front();
				req_type    <= r.kind;
				first_word  <= r.one;
				second_word <= r.two;
				req_valid   <= 1'b1;
				calm        <= (pair_reqs.size() < 60);
			end
		end else begin
			req_valid <= 1'b0;
		end
	end

	// receiver, with one long hold-off to back the table up
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else if (!held_once && accepted_n >= 40) begin
			held_once <= 1'b1;
			hold_left <= 80;
			res_stall <= 1'b1;
		end else if (calm) begin
			res_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_stall  <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 6);
			res_stall  <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		pair_req_t r;
		tally_t due;
		req_taken = arst_n && req_valid && !req_stall;
		if (arst_n && res_valid && !res_stall) begin
			if (due_tallies.size() == 0) begin
				$display("%0t unexpected word: status %0d count %0d", $time, status, pair_count);
				mismatches++;
			end else begin
				due = due_tallies.pop_front();
				if (status !== due.status) begin
					$display("%0t status mismatch: expected %0d got %0d",
						$time, due.status, status);
					mismatches++;
				end
				if (pair_count !== due.count) begin
					$display("%0t pair_count mismatch: expected %0d got %0d",
						$time, due.count, pair_count);
					mismatches++;
				end
			end
		end
		if (req_taken) begin
			r.kind = req_type;
			r.one  = first_word;
			r.two  = second_word;
			due_tallies.push_back(tally_pair(r));
			accepted_n++;
		end
	end

	initial begin
		#8000000;
		$display("tb: errors");
		$finish;
	end

	initial begin
		logic [WORD_ID_BITS-1:0] a;
		logic [WORD_ID_BITS-1:0] b;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req_type    = REQ_INCR;
		first_word  = '0;
		second_word = '0;
		res_stall   = 1'b0;
		mismatches  = 0;
		accepted_n  = 0;
		req_taken   = 1'b0;
		calm        = 1'b0;
		gap_left    = 0;
		stall_left  = 0;
		hold_left   = 0;
		held_once   = 1'b0;
		slots_taken = 0;
		for (int i = 0; i < BUCKETS; i++)
			chain_head[i] = 0;

		vocab[0] = '0;
		vocab[1] = '1;
		for (int i = 2; i < 16; i++)
			vocab[i] = WORD_ID_BITS'($urandom);
		for (int i = 0; i < 4; i++)
			mate_lo[i] = WORD_ID_BITS'($urandom_range(0, (1 << BUCKET_BITS) - 1));
		mate_bkt[0] = BUCKET_BITS'($urandom);
		mate_bkt[1] = ~mate_bkt[0];

		// directed: miss on empty table, insert, both orders, self pairs, extreme words
		queue_req(REQ_LOOKUP, 20'd5, 20'd9);
		queue_req(REQ_INCR,   20'd5, 20'd9);
		queue_req(REQ_INCR,   20'd9, 20'd5);
		queue_req(REQ_LOOKUP, 20'd9, 20'd5);
		queue_req(REQ_INCR,   20'd7, 20'd7);
		queue_req(REQ_LOOKUP, '1, '1);
		queue_req(REQ_INCR,   '0, '0);
		queue_req(REQ_INCR,   '0, '1);
		queue_req(REQ_LOOKUP, '1, '0);
		queue_req(REQ_INCR,   '1, '0);
		queue_req(REQ_LOOKUP, '0, 20'd1);
		queue_req(REQ_INCR,   20'd1, 20'hFFFFE);
		// three pairs sharing one bucket, then hits and a miss down the chain
		a = 20'd3;
		queue_req(REQ_INCR,   a, bucket_mate(a, 10'd77, 10'd1));
		queue_req(REQ_INCR,   bucket_mate(a, 10'd77, 10'd2), a);
		queue_req(REQ_INCR,   a, bucket_mate(a, 10'd77, 10'd3));
		queue_req(REQ_LOOKUP, bucket_mate(a, 10'd77, 10'd1), a);
		queue_req(REQ_INCR,   a, bucket_mate(a, 10'd77, 10'd1));
		queue_req(REQ_LOOKUP, a, bucket_mate(a, 10'd77, 10'd2));
		queue_req(REQ_LOOKUP, a, bucket_mate(a, 10'd77, 10'd9));
		queue_req(REQ_INCR,   bucket_mate(a, 10'd77, 10'd9), a);

		for (int i = 0; i < 360; i++)
			pair_reqs.push_back(rand_pair());

		// insert in one order, look up in the other
		for (int j = 0; j < 4; j++) begin
			a = 20'h90000 + 20'(j);
			b = 20'h30000 + 20'(j);
			queue_req(REQ_INCR,   a, b);
			queue_req(REQ_LOOKUP, b, a);
		end
		queue_req(REQ_INCR,   20'd9, 20'd5);
		queue_req(REQ_LOOKUP, 20'd5, 20'd9);
		queue_req(REQ_INCR,   20'h40000, 20'h80000);
		queue_req(REQ_LOOKUP, 20'h80000, 20'h40000);
		queue_req(REQ_INCR,   20'd11, 20'd11);
		for (int i = 0; i < 60; i++)
			pair_reqs.push_back(rand_pair());

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pair_reqs.size() > 0 || req_valid)
			@(posedge clk);
		while (due_tallies.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && due_tallies.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
